### design/far_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_pkg
// Shared widths, codes and control types of the fade attenuation ramp.
// ----------------------------------------------------------------------------
package far_pkg;

   localparam int FRAME_W    = 18;
   localparam int FACTOR_W   = 13;
   localparam int QUOT_W     = 13;
   localparam int DIVIDEND_W = FRAME_W + FACTOR_W;
   localparam int ATTEN_W    = 14;
   localparam int KIND_W     = 3;
   localparam int ACTION_W   = 2;
   localparam int STEP_W     = 4;

   localparam logic [FRAME_W-1:0]  MAX_FRAMES = 18'd262143;
   localparam logic [FACTOR_W-1:0] FACTOR_DEEP    = 13'd5000;
   localparam logic [FACTOR_W-1:0] FACTOR_SHALLOW = 13'd1000;
   localparam logic [STEP_W-1:0]   DIV_LAST_STEP  = STEP_W'(QUOT_W - 1);

   localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

   localparam logic [KIND_W-1:0] KIND_NONE             = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FADE_OUT_STOP    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FADE_IN          = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FADE_IN_SHALLOW  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FADE_OUT_SHALLOW = 3'd4;

   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### design/fade_attenuation_ramp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fade_attenuation_ramp_core
// Per-frame volume fade generator with an iterative divider for the ramp.
//
//   channel  dir  tdata                                    tuser
//   req      in   fade_kind[2:0] frames[20:3]              action[1:0]
//   rsp      out  applied[0] finished[1] stop_request[2]   volume_valid
//                 attenuation[16:3]
//
// start, cancel and ticks without a new volume go through the finish state to the output
// a tick with a new volume first takes one multiply and 13 divide steps
// req_tready is high only while the sequencer is idle
// a result waiting on rsp_tready does not block the next request
// synchronous active-high reset clears the fade and all handshake state
// ----------------------------------------------------------------------------
module fade_attenuation_ramp_core
   import far_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // fade_kind, frames, zero pad
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // applied, finished, stop_request, attenuation, zero pad
   output logic        rsp_tuser    // volume_valid
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_LOAD = 5'b00100,
      S_DIV  = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [KIND_W-1:0]    active_kind_ff, active_kind_in;
   logic [FRAME_W-1:0]   frames_left_ff, frames_left_in;
   logic [FRAME_W-1:0]   fade_length_ff, fade_length_in;
   logic                 res_applied_ff, res_applied_in;
   logic                 res_finished_ff, res_finished_in;
   logic                 res_stop_ff, res_stop_in;
   logic                 res_valid_ff, res_valid_in;
   logic [KIND_W-1:0]    res_kind_ff, res_kind_in;
   logic [DIVIDEND_W-1:0] product_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_applied_ff, rsp_finished_ff, rsp_stop_ff, rsp_vol_ff;
   logic [ATTEN_W-1:0]   rsp_atten_ff;

   logic [ACTION_W-1:0]  req_action;
   logic [KIND_W-1:0]    req_kind;
   logic [FRAME_W-1:0]   req_frames;
   logic [FRAME_W-1:0]   start_len;
   logic                 req_fire;
   logic                 rsp_free;
   logic                 deep;
   logic                 to_floor;
   logic [FACTOR_W-1:0]  factor;
   logic [ATTEN_W-1:0]   atten;
   logic [QUOT_W-1:0]    quotient;
   div_ctrl_type         div_ctrl;
   div_stat_type         div_stat;

   assign req_action = req_tuser;
   assign req_kind   = req_tdata[2:0];
   assign req_frames = req_tdata[20:3];
   assign start_len  = (req_frames > MAX_FRAMES) ? MAX_FRAMES : req_frames;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign deep     = (res_kind_ff == KIND_FADE_OUT_STOP) || (res_kind_ff == KIND_FADE_IN);
   assign to_floor = (res_kind_ff == KIND_FADE_OUT_STOP) ||
                     (res_kind_ff == KIND_FADE_OUT_SHALLOW);
   assign factor   = deep ? FACTOR_DEEP : FACTOR_SHALLOW;

   always_comb begin
      if (!res_valid_ff) begin
         atten = '0;
      end else if (to_floor) begin
         atten = {1'b0, quotient} - {1'b0, factor};
      end else begin
         atten = '0 - {1'b0, quotient};
      end
   end

   assign div_ctrl.start = (state_ff == S_LOAD);

   far_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (product_ff),
      .divisor  (fade_length_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      state_in        = state_ff;
      active_kind_in  = active_kind_ff;
      frames_left_in  = frames_left_ff;
      fade_length_in  = fade_length_ff;
      res_applied_in  = res_applied_ff;
      res_finished_in = res_finished_ff;
      res_stop_in     = res_stop_ff;
      res_valid_in    = res_valid_ff;
      res_kind_in     = res_kind_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_applied_in  = 1'b0;
               res_finished_in = 1'b0;
               res_stop_in     = 1'b0;
               res_valid_in    = 1'b0;
               res_kind_in     = req_kind;
               state_in        = S_FIN;
               case (req_action)
                  ACT_START: begin
                     fade_length_in = start_len;
                     frames_left_in = start_len;
                     active_kind_in = ((req_kind >= KIND_FADE_OUT_STOP) &&
                                       (req_kind <= KIND_FADE_OUT_SHALLOW)) ?
                                      req_kind : KIND_NONE;
                  end
                  ACT_CANCEL: begin
                     active_kind_in = KIND_NONE;
                  end
                  ACT_TICK: begin
                     if ((req_kind != KIND_NONE) && (req_kind == active_kind_ff)) begin
                        res_applied_in = 1'b1;
                        if (frames_left_ff <= FRAME_W'(1)) begin
                           frames_left_in  = '0;
                           active_kind_in  = KIND_NONE;
                           res_finished_in = 1'b1;
                           res_stop_in     = (req_kind == KIND_FADE_OUT_STOP);
                        end else begin
                           frames_left_in = frames_left_ff - 1'b1;
                           res_valid_in   = 1'b1;
                           state_in       = S_MUL;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL:  state_in = S_LOAD;
         S_LOAD: state_in = S_DIV;
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         active_kind_ff <= KIND_NONE;
         frames_left_ff <= '0;
         fade_length_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_kind_ff <= active_kind_in;
         frames_left_ff <= frames_left_in;
         fade_length_ff <= fade_length_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_applied_ff  <= res_applied_in;
      res_finished_ff <= res_finished_in;
      res_stop_ff     <= res_stop_in;
      res_valid_ff    <= res_valid_in;
      res_kind_ff     <= res_kind_in;
      if (state_ff == S_MUL) begin
         product_ff <= DIVIDEND_W'(frames_left_ff * factor);
      end
      if ((state_ff == S_FIN) && rsp_free) begin
         rsp_applied_ff  <= res_applied_ff;
         rsp_finished_ff <= res_finished_ff;
         rsp_stop_ff     <= res_stop_ff;
         rsp_vol_ff      <= res_valid_ff;
         rsp_atten_ff    <= atten;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_vol_ff;
   assign rsp_tdata  = {7'd0, rsp_atten_ff, rsp_stop_ff, rsp_finished_ff, rsp_applied_ff};

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_stat.busy) else $error("divider busy while idle");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV)) else $error("divider done out of sequence");
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) && res_valid_ff |-> ({1'b0, quotient} < {1'b0, factor}))
      else $error("quotient out of range");
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      active_kind_ff <= KIND_FADE_OUT_SHALLOW) else $error("illegal active kind");

endmodule

### design/far_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_divider
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module far_divider
   import far_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  div_ctrl_type          ctrl,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [FRAME_W-1:0]    divisor,
   output div_stat_type          stat,
   output logic [QUOT_W-1:0]     quotient
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [FRAME_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]   quo_ff, quo_in;
   logic [FRAME_W-1:0]  dvs_ff, dvs_in;
   logic [FRAME_W:0]    trial;
   logic [FRAME_W:0]    diff;
   logic                fits;

   assign trial = {rem_ff, quo_ff[QUOT_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = DIV_LAST_STEP;
         rem_in  = dividend[DIVIDEND_W-1:QUOT_W];
         quo_in  = dividend[QUOT_W-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[FRAME_W-1:0] : trial[FRAME_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("divider done without run");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && (step_ff != '0) |-> !ctrl.start) else $error("divider restarted");

endmodule

### bench/tb_fade_attenuation_ramp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fade_attenuation_ramp_core
// Self-checking bench for the fade ramp core. A directed table covers reset
// behavior, duration extremes, every fade kind, cancel, the ignored action and
// fade end with and without a stop. Random fade sequences with ticks follow.
// Each result is checked against its table row or a cycle-free model of the fade state. The
// sender runs in bursts. The receiver stalls on its own pattern and holds off
// once for a long stretch, so the core fills up and stops taking requests.
// ----------------------------------------------------------------------------
module tb_fade_attenuation_ramp_core;
   import far_pkg::*;

   localparam int RANDOM_ITEMS = 1100;
   localparam int IDLE_LIMIT   = 4000;
   localparam int LONG_HOLD    = 700;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [ACTION_W-1:0] act;
      logic [KIND_W-1:0]   kind;
      logic [FRAME_W-1:0]  frames;
   } fade_request_type;

   typedef struct packed {
      logic                      applied;
      logic                      finished;
      logic                      stop_request;
      logic                      volume_valid;
      logic signed [ATTEN_W-1:0] attenuation;
   } fade_result_type;

   typedef struct packed {
      fade_request_type rq;
      logic             typed;
      fade_result_type  want;
   } fade_row_type;

   localparam fade_result_type QUIET    = '0;
   localparam fade_result_type END_STOP = '{1'b1, 1'b1, 1'b1, 1'b0, 14'sd0};
   localparam fade_result_type END_KEEP = '{1'b1, 1'b1, 1'b0, 1'b0, 14'sd0};

   localparam int N_ROWS = 26;

   fade_row_type directed_rows [0:N_ROWS-1] = '{
      '{'{ACT_TICK,   KIND_FADE_OUT_STOP,    18'd0},     1'b1, QUIET},
      '{'{ACT_NONE,   3'd7,                  MAX_FRAMES}, 1'b1, QUIET},
      '{'{ACT_START,  3'd7,                  MAX_FRAMES}, 1'b1, QUIET},
      '{'{ACT_TICK,   3'd7,                  18'd0},     1'b1, QUIET},
      '{'{ACT_START,  KIND_FADE_OUT_STOP,    18'd0},     1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_OUT_STOP,    18'd0},     1'b1, END_STOP},
      '{'{ACT_START,  KIND_FADE_IN,          MAX_FRAMES}, 1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_IN,          MAX_FRAMES}, 1'b0, QUIET},
      '{'{ACT_TICK,   KIND_FADE_IN_SHALLOW,  18'd0},     1'b1, QUIET},
      '{'{ACT_TICK,   KIND_NONE,             18'd0},     1'b1, QUIET},
      '{'{ACT_CANCEL, 3'd7,                  MAX_FRAMES}, 1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_IN,          18'd0},     1'b1, QUIET},
      '{'{ACT_START,  KIND_FADE_IN_SHALLOW,  18'd2},     1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_IN_SHALLOW,  18'd0},     1'b0, QUIET},
      '{'{ACT_TICK,   KIND_FADE_IN_SHALLOW,  18'd0},     1'b1, END_KEEP},
      '{'{ACT_START,  KIND_FADE_OUT_SHALLOW, 18'd1},     1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_OUT_SHALLOW, 18'd0},     1'b1, END_KEEP},
      '{'{ACT_START,  KIND_FADE_OUT_STOP,    18'd3},     1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_OUT_STOP,    18'd0},     1'b0, QUIET},
      '{'{ACT_TICK,   KIND_FADE_OUT_STOP,    18'd0},     1'b0, QUIET},
      '{'{ACT_TICK,   KIND_FADE_OUT_STOP,    18'd0},     1'b1, END_STOP},
      '{'{ACT_START,  KIND_FADE_OUT_SHALLOW, MAX_FRAMES}, 1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_OUT_SHALLOW, 18'd0},     1'b0, QUIET},
      '{'{ACT_START,  KIND_FADE_IN,          18'd1},     1'b1, QUIET},
      '{'{ACT_TICK,   KIND_FADE_IN,          18'd0},     1'b1, END_KEEP},
      '{'{ACT_START,  KIND_NONE,             18'd5},     1'b1, QUIET}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // fade_kind, frames, zero pad
   logic [1:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // applied, finished, stop_request, attenuation, zero pad
   logic        rsp_tuser;   // volume_valid

   // fade state as the core should hold it
   logic [KIND_W-1:0]  active_fade;
   logic [19:0]        frames_remaining;
   logic [FRAME_W-1:0] fade_span;

   fade_result_type expected_results [$];
   int              mismatch_count;
   int              results_seen;
   int              requests_sent;
   int              burst_left;
   int              idle_cycles;

   fade_attenuation_ramp_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic fade_result_type compute_fade_step(fade_request_type rq);
      fade_result_type   res;
      longint unsigned   factor;
      longint unsigned   quot;
      res = '0;
      case (rq.act)
         ACT_START: begin
            fade_span = (rq.frames > MAX_FRAMES) ? MAX_FRAMES : rq.frames;
            frames_remaining = {2'b00, fade_span};
            active_fade = (rq.kind >= KIND_FADE_OUT_STOP && rq.kind <= KIND_FADE_OUT_SHALLOW)
                          ? rq.kind : KIND_NONE;
         end
         ACT_CANCEL: active_fade = KIND_NONE;
         ACT_TICK: begin
            if (rq.kind != KIND_NONE && rq.kind == active_fade) begin
               res.applied = 1'b1;
               if (frames_remaining <= 20'd1) begin
                  frames_remaining = '0;
                  active_fade = KIND_NONE;
                  res.finished = 1'b1;
                  res.stop_request = (rq.kind == KIND_FADE_OUT_STOP);
               end else begin
                  factor = (rq.kind == KIND_FADE_OUT_STOP || rq.kind == KIND_FADE_IN)
                           ? FACTOR_DEEP : FACTOR_SHALLOW;
                  frames_remaining = frames_remaining - 20'd1;
                  quot = (fade_span != '0) ? (frames_remaining * factor) / fade_span : 0;
                  if (rq.kind == KIND_FADE_OUT_STOP || rq.kind == KIND_FADE_OUT_SHALLOW) begin
                     res.attenuation = ATTEN_W'(quot - factor);
                  end else begin
                     res.attenuation = ATTEN_W'(-quot);
                  end
                  res.volume_valid = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic fade_request_type make_request(logic [ACTION_W-1:0] act,
                                                     logic [KIND_W-1:0] kind,
                                                     logic [FRAME_W-1:0] frames);
      fade_request_type rq;
      rq.act    = act;
      rq.kind   = kind;
      rq.frames = frames;
      return rq;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input fade_request_type rq, input logic typed,
                               input fade_result_type want);
      fade_result_type pred;
      int              gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left = burst_left - 1;
      req_tvalid = 1'b1;
      req_tdata  = {3'b000, rq.frames, rq.kind};
      req_tuser  = rq.act;
      do @(posedge clock); while (!req_tready);
      pred = compute_fade_step(rq);
      expected_results.push_back(typed ? want : pred);
      if (rq.act != ACT_NONE) requests_sent = requests_sent + 1;
      @(negedge clock);
   endtask

   // stimulus
   initial begin
      fade_request_type  rq;
      logic [KIND_W-1:0] k;
      int                len;
      int                ticks;
      int                pick;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = ACT_TICK;
      active_fade      = KIND_NONE;
      frames_remaining = '0;
      fade_span        = '0;
      mismatch_count   = 0;
      requests_sent    = 0;
      burst_left       = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_ROWS; i++) begin
         send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
      end

      requests_sent = 0;
      while (requests_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            // a fade run: start, then mostly ticks of its kind
            k   = KIND_W'($urandom_range(1, 4));
            len = ($urandom_range(0, 9) == 0) ? int'(FRAME_W'($urandom))
                                               : $urandom_range(0, 30);
            send_request(make_request(ACT_START, k, FRAME_W'(len)), 1'b0, QUIET);
            ticks = (len > 36) ? $urandom_range(1, 40) : $urandom_range(1, len + 3);
            for (int t = 0; t < ticks; t++) begin
               pick = $urandom_range(0, 99);
               if (pick < 84) begin
                  rq = make_request(ACT_TICK, k, FRAME_W'($urandom));
               end else if (pick < 94) begin
                  rq = make_request(ACT_TICK, KIND_W'($urandom), FRAME_W'($urandom));
               end else if (pick < 97) begin
                  rq = make_request(ACT_CANCEL, KIND_W'($urandom), FRAME_W'($urandom));
               end else begin
                  rq = make_request(ACT_NONE, KIND_W'($urandom), FRAME_W'($urandom));
               end
               send_request(rq, 1'b0, QUIET);
            end
         end else begin
            rq = make_request(ACTION_W'($urandom), KIND_W'($urandom), FRAME_W'($urandom));
            send_request(rq, 1'b0, QUIET);
         end
      end
      req_tvalid = 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_fade_attenuation_ramp_core: done, clean");
      end else begin
         $display("tb_fade_attenuation_ramp_core: done, errors");
      end
      $finish;
   end

   // receiver stall pattern, with one long hold-off
   initial begin
      int seg_left;
      int seg_mode;
      bit held;
      rsp_tready = 1'b0;
      seg_left   = 0;
      seg_mode   = 0;
      held       = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= 200) begin
            held = 1'b1;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 3);
            seg_left = $urandom_range(8, 80);
         end
         seg_left = seg_left - 1;
         case (seg_mode)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = $urandom_range(0, 1);
            2:       rsp_tready = ($urandom_range(0, 7) != 0);
            default: rsp_tready = ((seg_left % 7) < 2);
         endcase
      end
   end

   // result check
   always @(posedge clock) begin
      fade_result_type got;
      fade_result_type want;
      if (reset) begin
         results_seen <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         got.applied      = rsp_tdata[0];
         got.finished     = rsp_tdata[1];
         got.stop_request = rsp_tdata[2];
         got.attenuation  = rsp_tdata[16:3];
         got.volume_valid = rsp_tuser;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_results.pop_front();
            if (got.applied !== want.applied) begin
               $error("applied: expected %0d, got %0d", want.applied, got.applied);
               mismatch_count = mismatch_count + 1;
            end
            if (got.finished !== want.finished) begin
               $error("finished: expected %0d, got %0d", want.finished, got.finished);
               mismatch_count = mismatch_count + 1;
            end
            if (got.stop_request !== want.stop_request) begin
               $error("stop_request: expected %0d, got %0d",
                      want.stop_request, got.stop_request);
               mismatch_count = mismatch_count + 1;
            end
            if (got.volume_valid !== want.volume_valid) begin
               $error("volume_valid: expected %0d, got %0d",
                      want.volume_valid, got.volume_valid);
               mismatch_count = mismatch_count + 1;
            end
            if (got.attenuation !== want.attenuation) begin
               $error("attenuation: expected %0d, got %0d",
                      want.attenuation, got.attenuation);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_fade_attenuation_ramp_core: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

### sim.f
design/far_pkg.sv
design/far_divider.sv
design/fade_attenuation_ramp_core.sv
bench/tb_fade_attenuation_ramp_core.sv
